@@ sv/dercu_pkg.sv @@
// ----------------------------------------------------------------------------
// dercu_pkg
// Shared types and constants of the data EEPROM register controller.
// ----------------------------------------------------------------------------
package dercu_pkg;

    // Storage geometry (MEM_DEPTH must be a power of two, 16 to 1024)
    localparam int MEM_DEPTH = 1024;
    localparam int IDX_W     = $clog2(MEM_DEPTH);
    localparam int ADDR_W    = 10;

    typedef logic [IDX_W-1:0] idx_t;
    localparam idx_t IDX_LAST = idx_t'(MEM_DEPTH - 1);

    // Input modes
    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;

    // Register selects
    localparam logic [2:0] SEL_ADDRL  = 3'd0;
    localparam logic [2:0] SEL_ADDRH  = 3'd1;
    localparam logic [2:0] SEL_DATA   = 3'd2;
    localparam logic [2:0] SEL_CTRL   = 3'd3;
    localparam logic [2:0] SEL_UNLOCK = 3'd4;

    // Classified operations
    localparam logic [3:0] OP_NOP       = 4'd0;
    localparam logic [3:0] OP_RD_ADDRL  = 4'd1;
    localparam logic [3:0] OP_RD_ADDRH  = 4'd2;
    localparam logic [3:0] OP_RD_DATA   = 4'd3;
    localparam logic [3:0] OP_RD_CTRL   = 4'd4;
    localparam logic [3:0] OP_WR_ADDRL  = 4'd5;
    localparam logic [3:0] OP_WR_ADDRH  = 4'd6;
    localparam logic [3:0] OP_WR_DATA   = 4'd7;
    localparam logic [3:0] OP_WR_CTRL   = 4'd8;
    localparam logic [3:0] OP_WR_UNLOCK = 4'd9;
    localparam logic [3:0] OP_TICK      = 4'd10;

    // Control register bits
    localparam int CTL_PGD = 7;
    localparam int CTL_CFG = 6;
    localparam int CTL_WEN = 2;
    localparam int CTL_WR  = 1;
    localparam int CTL_RD  = 0;
    localparam logic [7:0] CTL_KEEP_MASK = 8'hC4;

    // Unlock tracking
    localparam logic [7:0] UNLOCK_KEY1 = 8'h55;
    localparam logic [7:0] UNLOCK_KEY2 = 8'hAA;
    localparam logic [1:0] ULK_LOCKED  = 2'd0;
    localparam logic [1:0] ULK_KEY1    = 2'd1;
    localparam logic [1:0] ULK_OPEN    = 2'd2;

    localparam logic [7:0]  ERASED_BYTE    = 8'hFF;
    localparam logic [15:0] WR_CYCLES_INIT = 16'd40;

    typedef struct packed {
        logic [3:0] op;
        logic [7:0] wdata;
    } item_t;

endpackage

@@ sv/dercu_ram.sv @@
// ----------------------------------------------------------------------------
// dercu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dercu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/dercu_front.sv @@
// ----------------------------------------------------------------------------
// dercu_front
// Accept bus items, decode them into operations and queue them (two deep).
// ----------------------------------------------------------------------------
module dercu_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        mode,
    input  logic [2:0]        reg_sel,
    input  logic [7:0]        write_data,
    input  logic              hold,
    output logic              q_valid,
    output dercu_pkg::item_t  q_item,
    input  logic              q_pop
);

    dercu_pkg::item_t ent_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       cnt_reg, cnt_next;
    dercu_pkg::item_t dec_item;
    logic             push;

    // Decode mode and select into one operation code
    always_comb
    begin
        dec_item.op    = dercu_pkg::OP_NOP;
        dec_item.wdata = write_data;
        case (mode)
            dercu_pkg::MODE_READ:
            begin
                case (reg_sel)
                    dercu_pkg::SEL_ADDRL: dec_item.op = dercu_pkg::OP_RD_ADDRL;
                    dercu_pkg::SEL_ADDRH: dec_item.op = dercu_pkg::OP_RD_ADDRH;
                    dercu_pkg::SEL_DATA:  dec_item.op = dercu_pkg::OP_RD_DATA;
                    dercu_pkg::SEL_CTRL:  dec_item.op = dercu_pkg::OP_RD_CTRL;
                    default:              dec_item.op = dercu_pkg::OP_NOP;
                endcase
            end
            dercu_pkg::MODE_WRITE:
            begin
                case (reg_sel)
                    dercu_pkg::SEL_ADDRL:  dec_item.op = dercu_pkg::OP_WR_ADDRL;
                    dercu_pkg::SEL_ADDRH:  dec_item.op = dercu_pkg::OP_WR_ADDRH;
                    dercu_pkg::SEL_DATA:   dec_item.op = dercu_pkg::OP_WR_DATA;
                    dercu_pkg::SEL_CTRL:   dec_item.op = dercu_pkg::OP_WR_CTRL;
                    dercu_pkg::SEL_UNLOCK: dec_item.op = dercu_pkg::OP_WR_UNLOCK;
                    default:               dec_item.op = dercu_pkg::OP_NOP;
                endcase
            end
            dercu_pkg::MODE_TICK: dec_item.op = dercu_pkg::OP_TICK;
            default:              dec_item.op = dercu_pkg::OP_NOP;
        endcase
    end

    assign in_ready = (cnt_reg != 2'd2) && !hold;
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = ent_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push  ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= dec_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

@@ sv/dercu_back.sv @@
// ----------------------------------------------------------------------------
// dercu_back
// Execute queued operations on the register file and EEPROM array, erase the
// array after reset, and register each result.
// ----------------------------------------------------------------------------
module dercu_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [15:0]            cfg_wdata,
    input  logic                   q_valid,
    input  dercu_pkg::item_t       q_item,
    output logic                   q_pop,
    output logic                   clearing,
    output logic                   ram_we,
    output dercu_pkg::idx_t        ram_waddr,
    output logic [7:0]             ram_wdata,
    output logic                   ram_re,
    output dercu_pkg::idx_t        ram_raddr,
    input  logic [7:0]             ram_rdata,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [7:0]             read_data,
    output logic                   write_busy
);

    logic [15:0]                  wcyc_reg;
    logic [dercu_pkg::ADDR_W-1:0] addr_reg, addr_next;
    logic [7:0]                   data_reg, data_next;
    logic [7:0]                   ctrl_reg, ctrl_next;
    logic [1:0]                   ulk_reg, ulk_next;
    logic [15:0]                  busy_reg, busy_next;
    logic                         rd_pend_reg, rd_pend_next;
    logic                         clr_reg;
    dercu_pkg::idx_t              clr_cnt_reg;
    logic                         out_valid_reg, out_valid_next;
    logic [7:0]                   rdat_reg, rdat_next;
    logic                         wbusy_reg, wbusy_next;

    logic            fire;
    logic [7:0]      data_eff;
    logic [7:0]      v;
    logic            data_space;
    logic            rd_act;
    logic            wr_start;
    dercu_pkg::idx_t idx;

    assign fire     = q_valid && !clr_reg && (!out_valid_reg || out_ready);
    assign q_pop    = fire;
    assign clearing = clr_reg;
    assign idx      = addr_reg[dercu_pkg::IDX_W-1:0];

    // A read strobe issued last cycle lands here; forward the RAM output
    assign data_eff = rd_pend_reg ? ram_rdata : data_reg;

    assign v          = q_item.wdata;
    assign data_space = !v[dercu_pkg::CTL_PGD] && !v[dercu_pkg::CTL_CFG];
    assign rd_act     = fire && (q_item.op == dercu_pkg::OP_WR_CTRL)
                        && v[dercu_pkg::CTL_RD] && data_space;
    assign wr_start   = fire && (q_item.op == dercu_pkg::OP_WR_CTRL)
                        && v[dercu_pkg::CTL_WR] && !ctrl_reg[dercu_pkg::CTL_WR]
                        && (ulk_reg == dercu_pkg::ULK_OPEN)
                        && v[dercu_pkg::CTL_WEN] && data_space;

    always_comb
    begin
        addr_next    = addr_reg;
        data_next    = data_eff;
        ctrl_next    = ctrl_reg;
        ulk_next     = ulk_reg;
        busy_next    = busy_reg;
        rd_pend_next = rd_act;
        rdat_next    = 8'd0;
        if (fire)
        begin
            case (q_item.op)
                dercu_pkg::OP_RD_ADDRL: rdat_next = addr_reg[7:0];
                dercu_pkg::OP_RD_ADDRH: rdat_next = {6'd0, addr_reg[9:8]};
                dercu_pkg::OP_RD_DATA:  rdat_next = data_eff;
                dercu_pkg::OP_RD_CTRL:  rdat_next = ctrl_reg;
                dercu_pkg::OP_WR_ADDRL:
                begin
                    addr_next = {addr_reg[9:8], v};
                    ulk_next  = dercu_pkg::ULK_LOCKED;
                end
                dercu_pkg::OP_WR_ADDRH:
                begin
                    addr_next = {v[1:0], addr_reg[7:0]};
                    ulk_next  = dercu_pkg::ULK_LOCKED;
                end
                dercu_pkg::OP_WR_DATA:
                begin
                    data_next = v;
                    ulk_next  = dercu_pkg::ULK_LOCKED;
                end
                dercu_pkg::OP_WR_CTRL:
                begin
                    ctrl_next = (v & dercu_pkg::CTL_KEEP_MASK)
                                | (ctrl_reg & 8'h02);
                    if (wr_start)
                    begin
                        ctrl_next[dercu_pkg::CTL_WR] = 1'b1;
                        busy_next = (wcyc_reg == 16'd0) ? 16'd1 : wcyc_reg;
                    end
                    ulk_next = dercu_pkg::ULK_LOCKED;
                end
                dercu_pkg::OP_WR_UNLOCK:
                begin
                    if (v == dercu_pkg::UNLOCK_KEY1)
                    begin
                        ulk_next = dercu_pkg::ULK_KEY1;
                    end
                    else if (v == dercu_pkg::UNLOCK_KEY2 && ulk_reg == dercu_pkg::ULK_KEY1)
                    begin
                        ulk_next = dercu_pkg::ULK_OPEN;
                    end
                    else
                    begin
                        ulk_next = dercu_pkg::ULK_LOCKED;
                    end
                end
                dercu_pkg::OP_TICK:
                begin
                    if (busy_reg != 16'd0)
                    begin
                        busy_next = busy_reg - 16'd1;
                        if (busy_reg == 16'd1)
                        begin
                            ctrl_next[dercu_pkg::CTL_WR] = 1'b0;
                        end
                    end
                end
                default: rdat_next = 8'd0;
            endcase
        end
        wbusy_next     = fire ? ctrl_next[dercu_pkg::CTL_WR] : wbusy_reg;
        out_valid_next = fire ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
        if (!fire)
        begin
            rdat_next = rdat_reg;
        end
    end

    // RAM port use: erase sweep first, then program writes. A write that starts
    // together with a read strobe stores the byte just read, so drop it.
    always_comb
    begin
        ram_re    = rd_act;
        ram_raddr = idx;
        if (clr_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = dercu_pkg::ERASED_BYTE;
        end
        else
        begin
            ram_we    = wr_start && !rd_act;
            ram_waddr = idx;
            ram_wdata = data_eff;
        end
    end

    always_ff @(posedge clk)
    begin
        rdat_reg <= rdat_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wcyc_reg      <= dercu_pkg::WR_CYCLES_INIT;
            addr_reg      <= '0;
            data_reg      <= 8'd0;
            ctrl_reg      <= 8'd0;
            ulk_reg       <= dercu_pkg::ULK_LOCKED;
            busy_reg      <= 16'd0;
            rd_pend_reg   <= 1'b0;
            clr_reg       <= 1'b1;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            wbusy_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                wcyc_reg <= cfg_wdata;
            end
            addr_reg      <= addr_next;
            data_reg      <= data_next;
            ctrl_reg      <= ctrl_next;
            ulk_reg       <= ulk_next;
            busy_reg      <= busy_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
            wbusy_reg     <= wbusy_next;
            if (clr_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == dercu_pkg::IDX_LAST)
                begin
                    clr_reg <= 1'b0;
                end
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_data  = rdat_reg;
    assign write_busy = wbusy_reg;

endmodule

@@ sv/data_eeprom_register_controller_unit.sv @@
// ----------------------------------------------------------------------------
// data_eeprom_register_controller_unit
// Bus model of a byte-wide data EEPROM with an unlock-guarded write cycle.
// ----------------------------------------------------------------------------
// Each item is one register read, one register write or one time tick, and
// each item yields exactly one result (read_data, write_busy). A front stage
// decodes items into operations and holds up to two in a queue; a back stage
// executes one operation per cycle, while no finished result waits and no
// erase runs, against the address, data, control and unlock registers and
// the 1024-byte array, and registers the result. An accepted item waits in
// the queue until the back stage executes it; with results taken every cycle
// one item goes in and one result comes out each cycle, and while a finished
// result waits the queue takes up to two more items and then holds intake.
// The array sits in a RAM with one write and one registered read port; a read
// strobe data byte is forwarded from the RAM output to the next operation.
// After reset the back stage erases all 1024 bytes to 0xFF, one byte per
// cycle, and the block accepts no item until that sweep ends (configuration
// writes are taken at any time). write_cycles resets to 40; the user must write
// it through cfg_we/cfg_wdata only while the block is idle (not enforced).
// ----------------------------------------------------------------------------
module data_eeprom_register_controller_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [2:0]  reg_sel,
    input  logic [7:0]  write_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  read_data,
    output logic        write_busy
);

    // Queue head between front and back
    logic             q_valid;
    dercu_pkg::item_t q_item;
    logic             q_pop;
    logic             clearing;

    // Array port
    logic            ram_we;
    dercu_pkg::idx_t ram_waddr;
    logic [7:0]      ram_wdata;
    logic            ram_re;
    dercu_pkg::idx_t ram_raddr;
    logic [7:0]      ram_rdata;

    // Accept and decode; hold intake while the array is being erased
    dercu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .reg_sel    (reg_sel),
        .write_data (write_data),
        .hold       (clearing),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    // Execute and register results
    dercu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .clearing   (clearing),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_data  (read_data),
        .write_busy (write_busy)
    );

    // EEPROM array storage
    dercu_ram #(
        .WIDTH (8),
        .DEPTH (dercu_pkg::MEM_DEPTH)
    ) u_array (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule
